// ===== hw/rtl/led_ring_bargraph_renderer_macros.svh =====
// ---------------------------------------------------------------------------
// LED ring bar-graph renderer assertion macros
// Concurrent assertion wrappers clocked by clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef LED_RING_BARGRAPH_RENDERER_MACROS_SVH
`define LED_RING_BARGRAPH_RENDERER_MACROS_SVH

`ifndef SYNTH
`define LRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LRB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define LRB_ASSERT(lbl, prop, msg)
`define LRB_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== hw/rtl/lrb_pkg.sv =====
// ---------------------------------------------------------------------------
// LED ring bar-graph renderer package
// Shared constants, mode codes and the records passed between the stages.
// ---------------------------------------------------------------------------
`default_nettype none

package lrb_pkg;

  localparam int unsigned LedsPerRing = 16;
  localparam int unsigned PixW        = $clog2(LedsPerRing);
  localparam int unsigned FullLevel   = 255;
  localparam int unsigned PctMax      = 100;
  localparam int unsigned Recip100    = 5243;
  localparam int unsigned RecipShift  = 19;
  localparam int unsigned PctW        = 7;
  localparam int unsigned ProdW       = 15;
  localparam int unsigned ScaledW     = ProdW + 13;

  localparam logic [PixW-1:0] LastPixel = PixW'(LedsPerRing - 1);

  localparam logic [0:0] RegBrightnessPercent = 1'b0;

  typedef enum logic [2:0] {
    OpSmoothBar   = 3'd0,
    OpCountFill   = 3'd1,
    OpDirectional = 3'd2,
    OpSweep       = 3'd3,
    OpBidir       = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]       ring_idx;
    op_e              op;
    logic [4:0]       count;
    logic             right_to_left;
    logic [4:0]       full_n;
    logic [ProdW-1:0] part_prod;
    logic [ProdW-1:0] full_prod;
  } item_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic [3:0] row;
    logic [3:0] column;
  } pixel_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lrb_cfg.sv =====
// ---------------------------------------------------------------------------
// LED ring bar-graph renderer register port
// APB-style access to the brightness percent register.
// ---------------------------------------------------------------------------
`default_nettype none

module lrb_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output logic      [lrb_pkg::PctW-1:0]  pct_o
);

  logic [lrb_pkg::PctW-1:0] pct_q, pct_d;
  logic                     hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == lrb_pkg::RegBrightnessPercent);

  always_comb begin
    pct_d = pct_q;
    if (psel && penable && pwrite && hit) begin
      pct_d = pwdata[lrb_pkg::PctW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q <= lrb_pkg::PctW'(lrb_pkg::PctMax);
    end else begin
      pct_q <= pct_d;
    end
  end

  assign prdata = hit ? {{(32 - lrb_pkg::PctW){1'b0}}, pct_q} : 32'd0;
  assign pct_o  = pct_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lrb_prep.sv =====
// ---------------------------------------------------------------------------
// LED ring bar-graph renderer request decode
// Checks the request and splits the fill level into whole LEDs and a rest.
// ---------------------------------------------------------------------------
`default_nettype none

module lrb_prep (
  input  wire logic [2:0]               ring_i,
  input  wire logic [2:0]               op_i,
  input  wire logic [7:0]               level_i,
  input  wire logic [4:0]               count_i,
  input  wire logic                     right_to_left_i,
  input  wire logic [lrb_pkg::PctW-1:0] pct_i,
  output logic                          valid_o,
  output lrb_pkg::item_t                item_o
);

  logic [11:0]                 scaled;
  logic [3:0]                  q0;
  logic [8:0]                  sum;
  logic [4:0]                  full_n;
  logic [7:0]                  rem;
  logic [lrb_pkg::PctW-1:0]    pct;
  logic [lrb_pkg::ProdW-1:0]   pct_w;

  // Dividing by 255: x = 256*q0 + r0 = 255*q0 + (q0 + r0), one correction.
  always_comb begin
    scaled = (op_i == lrb_pkg::OpBidir) ? {1'b0, level_i, 3'b000} : {level_i, 4'b0000};
    q0     = scaled[11:8];
    sum    = {1'b0, scaled[7:0]} + {5'd0, q0};
    if (sum >= 9'(lrb_pkg::FullLevel)) begin
      full_n = {1'b0, q0} + 5'd1;
      rem    = 8'(sum - 9'(lrb_pkg::FullLevel));
    end else begin
      full_n = {1'b0, q0};
      rem    = sum[7:0];
    end
  end

  assign pct   = (pct_i > lrb_pkg::PctW'(lrb_pkg::PctMax)) ?
                 lrb_pkg::PctW'(lrb_pkg::PctMax) : pct_i;
  assign pct_w = lrb_pkg::ProdW'(pct);

  assign valid_o = (ring_i >= 3'd1) && (ring_i <= 3'd5) && (op_i <= 3'(lrb_pkg::OpBidir));

  always_comb begin
    item_o               = '0;
    item_o.ring_idx      = ring_i - 3'd1;
    item_o.op            = lrb_pkg::op_e'(op_i);
    item_o.count         = (count_i > 5'(lrb_pkg::LedsPerRing)) ?
                           5'(lrb_pkg::LedsPerRing) : count_i;
    item_o.right_to_left = right_to_left_i;
    item_o.full_n        = full_n;
    item_o.part_prod     = lrb_pkg::ProdW'(rem) * pct_w;
    item_o.full_prod     = (pct_w << 8) - pct_w;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lrb_pixel.sv =====
// ---------------------------------------------------------------------------
// LED ring bar-graph renderer pixel logic
// Works out column, row and brightness of one LED of the current request.
// ---------------------------------------------------------------------------
`default_nettype none

module lrb_pixel (
  input  wire lrb_pkg::item_t           item_i,
  input  wire logic [lrb_pkg::PixW-1:0] idx_i,
  output lrb_pkg::pixel_t               pixel_o
);

  logic [lrb_pkg::ScaledW-1:0] full_sc, part_sc;
  logic [7:0]                  full_b, part_b, b;
  logic [3:0]                  pos;
  logic                        dir;
  logic [2:0]                  low;

  // Division by 100 through a reciprocal; exact for products up to 25500.
  assign full_sc = lrb_pkg::ScaledW'(item_i.full_prod) * lrb_pkg::ScaledW'(lrb_pkg::Recip100);
  assign part_sc = lrb_pkg::ScaledW'(item_i.part_prod) * lrb_pkg::ScaledW'(lrb_pkg::Recip100);
  assign full_b  = full_sc[lrb_pkg::RecipShift +: 8];
  assign part_b  = part_sc[lrb_pkg::RecipShift +: 8];

  always_comb begin
    dir = 1'b0;
    pos = idx_i;
    b   = 8'd0;
    unique case (item_i.op)
      lrb_pkg::OpSmoothBar: begin
        pos = idx_i;
      end
      lrb_pkg::OpCountFill: begin
        dir = item_i.right_to_left;
      end
      lrb_pkg::OpDirectional: begin
        dir = item_i.right_to_left;
      end
      lrb_pkg::OpSweep: begin
        dir = item_i.right_to_left;
        pos = idx_i[3] ? (4'd15 - idx_i) : (idx_i + 4'd8);
      end
      lrb_pkg::OpBidir: begin
        pos = idx_i[3] ? (4'd15 - idx_i) : idx_i;
      end
      default: begin
        pos = idx_i;
      end
    endcase

    if (item_i.op == lrb_pkg::OpCountFill) begin
      b = ({1'b0, idx_i} < item_i.count) ? full_b : 8'd0;
    end else if ({1'b0, pos} < item_i.full_n) begin
      b = full_b;
    end else if ({1'b0, pos} == item_i.full_n) begin
      b = part_b;
    end else begin
      b = 8'd0;
    end
  end

  always_comb begin
    low                = dir ? ~idx_i[2:0] : idx_i[2:0];
    pixel_o.brightness = b;
    if (item_i.ring_idx < 3'd4) begin
      pixel_o.row = {item_i.ring_idx, 1'b0} + {3'd0, idx_i[3]};
      if ((item_i.op == lrb_pkg::OpSweep) && idx_i[3]) begin
        pixel_o.column = {1'b0, dir ? idx_i[2:0] : ~idx_i[2:0]};
      end else begin
        pixel_o.column = {1'b0, low};
      end
    end else begin
      pixel_o.row    = idx_i[3] ? 4'd0 : 4'd8;
      pixel_o.column = {idx_i[3], low};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/led_ring_bargraph_renderer.sv =====
// ---------------------------------------------------------------------------
// LED ring bar-graph renderer
// Turns one ring request into sixteen pixel writes, with fractional fade in all modes but count fill.
// ---------------------------------------------------------------------------
//  channel   direction  tdata / tuser / tlast
//  s_axis    in         ring, level, led_count, right_to_left / operation / -
//  m_axis    out        column, row, brightness / - / last_pixel
//  apb       in/out     brightness_percent at address 0
//
// A valid request yields sixteen pixel writes, one per cycle while the output does
// not stall, set by the pixel counter that walks the held request.  The next request is
// taken in the cycle its predecessor's last pixel enters the output register, so
// requests run back to back.  A request with a bad ring or mode is taken and yields
// nothing.  Output stalls hold the counter.  Reset empties both stages and sets the
// brightness to 100 percent.
// ---------------------------------------------------------------------------
`default_nettype none

module led_ring_bargraph_renderer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] ring_number, [10:3] level, [15:11] led_count, [16] right_to_left
  input  wire logic [23:0] s_axis_tdata,
  // [2:0] operation
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] column, [7:4] row, [15:8] brightness
  output logic      [15:0] m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

`include "led_ring_bargraph_renderer_macros.svh"

  logic [lrb_pkg::PctW-1:0] pct;
  logic                     prep_valid;
  lrb_pkg::item_t           prep_item;
  lrb_pkg::pixel_t          pixel;

  logic                     busy_q, busy_d;
  lrb_pkg::item_t           item_q, item_d;
  logic [lrb_pkg::PixW-1:0] idx_q, idx_d;
  logic                     out_valid_q, out_valid_d;
  lrb_pkg::pixel_t          out_q, out_d;
  logic                     out_last_q, out_last_d;
  logic                     adv, accept, at_last;

  lrb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pct_o   (pct)
  );

  lrb_prep u_prep (
    .ring_i          (s_axis_tdata[2:0]),
    .op_i            (s_axis_tuser),
    .level_i         (s_axis_tdata[10:3]),
    .count_i         (s_axis_tdata[15:11]),
    .right_to_left_i (s_axis_tdata[16]),
    .pct_i           (pct),
    .valid_o         (prep_valid),
    .item_o          (prep_item)
  );

  lrb_pixel u_pixel (
    .item_i  (item_q),
    .idx_i   (idx_q),
    .pixel_o (pixel)
  );

  assign adv           = !out_valid_q || m_axis_tready;
  assign at_last       = (idx_q == lrb_pkg::LastPixel);
  assign s_axis_tready = !busy_q || (at_last && adv);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    busy_d      = busy_q;
    item_d      = item_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    out_last_d  = out_last_q;
    if (busy_q && adv) begin
      idx_d = idx_q + 1'b1;
      if (at_last) begin
        busy_d = 1'b0;
      end
    end
    if (accept) begin
      busy_d = prep_valid;
      item_d = prep_item;
      idx_d  = '0;
    end
    if (adv) begin
      out_valid_d = busy_q;
      out_d       = pixel;
      out_last_d  = at_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.brightness, out_q.row, out_q.column};
  assign m_axis_tlast  = out_last_q;

  `LRB_ASSERT(a_accept_at_end, busy_q && s_axis_tready |-> at_last, "request taken mid-burst")
  `LRB_ASSERT_NEXT(a_burst_continues, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "pixel burst broke off before its last write")
  `LRB_ASSERT(a_held_item_ok, busy_q |-> (item_q.ring_idx <= 3'd4) && (item_q.op <= lrb_pkg::OpBidir), "held request has a bad ring or mode")

endmodule

`default_nettype wire

// ===== sim/tb_led_ring_bargraph_renderer.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// LED ring bar-graph renderer testbench
// Sends ring requests with random bursts and gaps while the pixel sink stalls
// on patterns of its own. Each accepted valid request is expanded into sixteen
// expected pixel writes, and every pixel that leaves the block is compared
// with them. The brightness register is changed between phases.
// ---------------------------------------------------------------------------
module tb_led_ring_bargraph_renderer;

  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned ItemsPerPhase = 50;
  localparam int unsigned LedsPerRing   = lrb_pkg::LedsPerRing;
  localparam int unsigned HalfRing      = LedsPerRing / 2;
  localparam logic [2:0]  RingNone      = 3'd0;
  localparam logic [2:0]  RingFirst     = 3'd1;
  localparam logic [2:0]  RingLast      = 3'd5;
  localparam logic [2:0]  RingPastLast  = 3'd6;
  localparam logic [2:0]  RingMax       = 3'd7;
  localparam logic [2:0]  OpUnusedLo    = 3'd5;
  localparam logic [2:0]  OpUnusedHi    = 3'd7;
  localparam logic [6:0]  PctFieldMax   = 7'h7F;

  typedef struct packed {
    logic [3:0] column;
    logic [3:0] row;
    logic [7:0] brightness;
    logic       last;
  } pixel_write_t;

  class pixel_scoreboard;
    int unsigned  brightness_pct;
    int unsigned  errors;
    pixel_write_t pixel_q[$];

    function new();
      brightness_pct = lrb_pkg::PctMax;
      errors = 0;
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void note_request(logic [2:0] ring, logic [2:0] op, logic [7:0] level,
                               logic [4:0] count, logic rtl);
      int unsigned  pct, cnt, prod, full_n, rem, full_b, part_b, ri, pos, b, x, y;
      bit           dir;
      pixel_write_t w;
      if (ring < RingFirst || ring > RingLast || op > lrb_pkg::OpBidir) begin
        return;
      end
      ri = ring - RingFirst;
      pct = (brightness_pct > lrb_pkg::PctMax) ? lrb_pkg::PctMax : brightness_pct;
      cnt = (count > LedsPerRing) ? LedsPerRing : count;
      prod = level * ((op == lrb_pkg::OpBidir) ? HalfRing : LedsPerRing);
      full_n = prod / lrb_pkg::FullLevel;
      rem = prod % lrb_pkg::FullLevel;
      full_b = (lrb_pkg::FullLevel * pct) / lrb_pkg::PctMax;
      part_b = (rem * pct) / lrb_pkg::PctMax;
      dir = rtl && (op == lrb_pkg::OpCountFill || op == lrb_pkg::OpDirectional ||
                    op == lrb_pkg::OpSweep);
      for (int unsigned j = 0; j < LedsPerRing; j++) begin
        if (op == lrb_pkg::OpSweep) begin
          pos = (j < HalfRing) ? j + HalfRing : LedsPerRing - 1 - j;
        end else if (op == lrb_pkg::OpBidir) begin
          pos = (j < LedsPerRing - 1 - j) ? j : LedsPerRing - 1 - j;
        end else begin
          pos = j;
        end
        if (op == lrb_pkg::OpCountFill) begin
          b = (j < cnt) ? full_b : 0;
        end else if (pos < full_n) begin
          b = full_b;
        end else if (pos == full_n) begin
          b = part_b;
        end else begin
          b = 0;
        end
        if (ri < 4) begin
          y = ri * 2 + j / HalfRing;
          if (op == lrb_pkg::OpSweep && j >= HalfRing) begin
            x = dir ? j - HalfRing : LedsPerRing - 1 - j;
          end else begin
            x = dir ? HalfRing - 1 - (j % HalfRing) : j % HalfRing;
          end
        end else if (j < HalfRing) begin
          y = 8;
          x = dir ? HalfRing - 1 - j : j;
        end else begin
          y = 0;
          x = dir ? 23 - j : j;
        end
        w.column = x[3:0];
        w.row = y[3:0];
        w.brightness = b[7:0];
        w.last = (j == LedsPerRing - 1);
        pixel_q.push_back(w);
      end
    endfunction

    function void check_pixel(pixel_write_t got);
      pixel_write_t want;
      if (pixel_q.size() == 0) begin
        report("unrequested pixel, column", 0, got.column);
        return;
      end
      want = pixel_q.pop_front();
      if (got.column !== want.column) report("column", want.column, got.column);
      if (got.row !== want.row) report("row", want.row, got.row);
      if (got.brightness !== want.brightness) begin
        report("brightness", want.brightness, got.brightness);
      end
      if (got.last !== want.last) report("last pixel flag", want.last, got.last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pixel_scoreboard sb;
  int unsigned     cycles;
  int unsigned     burst_left;
  int unsigned     stall_mode;
  int unsigned     stall_span;
  int unsigned     stall_tick;

  led_ring_bargraph_renderer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) @(posedge clk_i);
    $display("tb_led_ring_bargraph_renderer: errors");
    $finish;
  end

  // The sink switches between always ready, random, mostly stalled and periodic.
  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(40, 300);
    end
    stall_span--;
    stall_tick++;
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= $urandom_range(0, 1);
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        m_axis_tready <= (stall_tick % 3 != 0);
      end
    endcase
  end

  always @(posedge clk_i) begin
    pixel_write_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.column = m_axis_tdata[3:0];
      got.row = m_axis_tdata[7:4];
      got.brightness = m_axis_tdata[15:8];
      got.last = m_axis_tlast;
      sb.check_pixel(got);
    end
  end

  task automatic send_request(logic [2:0] ring, logic [2:0] op, logic [7:0] level,
                              logic [4:0] count, logic rtl, bit allow_gaps);
    int unsigned gap;
    if (allow_gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, rtl, count, level, ring};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(ring, op, level, count, rtl);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pixel_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_brightness(logic [6:0] pct);
    logic [31:0] junk;
    junk = $urandom();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {lrb_pkg::RegBrightnessPercent, 2'b00};
    pwdata <= {junk[31:7], pct};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.brightness_pct = pct;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_phase(logic [6:0] pct, bit allow_gaps);
    int unsigned sent;
    logic [2:0]  ring;
    logic [2:0]  op;
    logic [7:0]  level;
    logic [4:0]  count;
    sent = 0;
    wait_idle();
    write_brightness(pct);
    while (sent < ItemsPerPhase) begin
      ring = $urandom_range(RingFirst, RingLast);
      op = $urandom_range(lrb_pkg::OpSmoothBar, lrb_pkg::OpBidir);
      if ($urandom_range(0, 9) == 0) begin
        ring = $urandom_range(RingNone, RingMax);
        op = $urandom_range(lrb_pkg::OpSmoothBar, OpUnusedHi);
      end
      case ($urandom_range(0, 5))
        0: level = 8'd0;
        1: level = 8'hFF;
        default: level = $urandom_range(0, 255);
      endcase
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 16);
      send_request(ring, op, level, count, $urandom_range(0, 1), allow_gaps);
      if (ring >= RingFirst && ring <= RingLast && op <= lrb_pkg::OpBidir) sent++;
    end
  endtask

  initial begin
    sb = new();
    burst_left = 0;
    stall_span = 0;
    stall_tick = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_request(RingFirst, lrb_pkg::OpSmoothBar, 8'd0, 5'd0, 1'b0, 1'b0);
    send_request(RingFirst, lrb_pkg::OpSmoothBar, 8'hFF, 5'd0, 1'b0, 1'b0);
    send_request(3'd2, lrb_pkg::OpSmoothBar, 8'd128, 5'd3, 1'b1, 1'b0);
    send_request(RingLast, lrb_pkg::OpSmoothBar, 8'd16, 5'd0, 1'b0, 1'b0);
    send_request(3'd3, lrb_pkg::OpCountFill, 8'd77, 5'd0, 1'b0, 1'b0);
    send_request(3'd4, lrb_pkg::OpCountFill, 8'd0, 5'd16, 1'b1, 1'b0);
    send_request(RingLast, lrb_pkg::OpCountFill, 8'hFF, 5'd31, 1'b0, 1'b0);
    send_request(RingLast, lrb_pkg::OpCountFill, 8'd9, 5'd17, 1'b1, 1'b0);
    send_request(3'd2, lrb_pkg::OpDirectional, 8'd100, 5'd0, 1'b0, 1'b0);
    send_request(RingLast, lrb_pkg::OpDirectional, 8'd200, 5'd0, 1'b1, 1'b0);
    send_request(3'd2, lrb_pkg::OpDirectional, 8'd254, 5'd31, 1'b1, 1'b0);
    send_request(3'd4, lrb_pkg::OpSweep, 8'd90, 5'd0, 1'b0, 1'b0);
    send_request(RingFirst, lrb_pkg::OpSweep, 8'hFF, 5'd0, 1'b1, 1'b0);
    send_request(RingLast, lrb_pkg::OpSweep, 8'd170, 5'd0, 1'b1, 1'b0);
    send_request(3'd3, lrb_pkg::OpBidir, 8'hFF, 5'd0, 1'b0, 1'b0);
    send_request(RingLast, lrb_pkg::OpBidir, 8'd1, 5'd0, 1'b1, 1'b0);
    send_request(3'd4, lrb_pkg::OpBidir, 8'd0, 5'd16, 1'b1, 1'b0);
    send_request(RingNone, lrb_pkg::OpSmoothBar, 8'hFF, 5'd0, 1'b0, 1'b0);
    send_request(RingPastLast, lrb_pkg::OpCountFill, 8'd40, 5'd8, 1'b1, 1'b0);
    send_request(RingMax, lrb_pkg::OpDirectional, 8'd60, 5'd0, 1'b0, 1'b0);
    send_request(RingFirst, OpUnusedLo, 8'd128, 5'd4, 1'b0, 1'b0);
    send_request(3'd3, OpUnusedHi, 8'hFF, 5'd16, 1'b1, 1'b0);

    random_phase(7'd0, 1'b1);
    random_phase(PctFieldMax, 1'b0);
    random_phase(7'd1, 1'b1);
    random_phase(7'd101, 1'b1);
    random_phase(7'd50, 1'b0);
    random_phase($urandom_range(0, 127), 1'b1);
    random_phase(7'd100, 1'b1);

    wait_idle();
    if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
      $display("tb_led_ring_bargraph_renderer: clean");
    end else begin
      $display("tb_led_ring_bargraph_renderer: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lrb_pkg.sv
hw/rtl/lrb_cfg.sv
hw/rtl/lrb_prep.sv
hw/rtl/lrb_pixel.sv
hw/rtl/led_ring_bargraph_renderer.sv
sim/tb_led_ring_bargraph_renderer.sv
